[rtl/core/time_ordered_event_queue_core_defines.svh]
// ----------------------------------------------------------------------------
// time ordered event queue - assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TIME_ORDERED_EVENT_QUEUE_CORE_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH
// clocked check, held off while reset is asserted
`define TOEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// clocked check, also active during reset
`define TOEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TOEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TOEQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/toeq_pkg.sv]
// ----------------------------------------------------------------------------
// toeq_pkg
// shared codes, state encoding and control/status bundles of the event queue
// ----------------------------------------------------------------------------
package toeq_pkg;

    localparam int unsigned ID_BITS    = 16;
    localparam int unsigned FUNC_BITS  = 2;
    localparam int unsigned STAT_BITS  = 2;
    localparam int unsigned COUNT_BITS = 5;
    localparam int unsigned PORT_TIME_BITS = 32;
    localparam int unsigned S_DATA_BITS = 48;
    localparam int unsigned M_DATA_BITS = 104;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_POP    = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_POS  = 2'd1,
        RD_K    = 2'd2,
        RD_KM1  = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_POS = 2'd0,
        WR_K   = 2'd1,
        WR_KM1 = 2'd2
    } wr_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_HEAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_INS_DECIDE,
        ST_SHIFT_UP_CHK,
        ST_SHIFT_UP_WR,
        ST_PUT,
        ST_POP_CAP,
        ST_SHIFT_DN_CHK,
        ST_SHIFT_DN_WR,
        ST_FIN_RD,
        ST_FIN_CAP
    } state_t;

    typedef struct packed {
        logic    load_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    wr_new;
        logic    pos_zero;
        logic    pos_one;
        logic    pos_occ;
        logic    pos_inc;
        logic    prev_load;
        logic    k_occ;
        logic    k_one;
        logic    k_dec;
        logic    k_inc;
        logic    occ_inc;
        logic    occ_dec;
        logic    pop_cap;
        logic    status_load;
        status_t status_val;
        logic    out_load;
    } toeq_cmd_t;

    typedef struct packed {
        func_t func;
        logic  occ_zero;
        logic  occ_full;
        logic  head_ge;
        logic  rd_le;
        logic  pos_lt_occ;
        logic  dup;
        logic  k_gt_pos;
        logic  k_lt_occ;
        logic  out_busy;
    } toeq_stat_t;

endpackage

[rtl/core/toeq_ctrl.sv]
// ----------------------------------------------------------------------------
// toeq_ctrl
// sequencer for insert scan, entry shifting, pop and result hand-off
// ----------------------------------------------------------------------------
module toeq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  toeq_pkg::toeq_stat_t stat,
    output toeq_pkg::toeq_cmd_t  cmd
);

    toeq_pkg::state_t state_reg;
    toeq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= toeq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            toeq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = toeq_pkg::ST_DISPATCH;
                end
            end
            toeq_pkg::ST_DISPATCH: begin
                case (stat.func)
                    toeq_pkg::FUNC_INSERT: begin
                        if (stat.occ_zero) begin
                            cmd.pos_zero = 1'b1;
                            cmd.k_occ    = 1'b1;
                            state_next   = toeq_pkg::ST_SHIFT_UP_CHK;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = toeq_pkg::RD_ZERO;
                            state_next = toeq_pkg::ST_INS_HEAD;
                        end
                    end
                    toeq_pkg::FUNC_APPEND: begin
                        if (stat.occ_full) begin
                            cmd.status_load = 1'b1;
                            cmd.status_val  = toeq_pkg::STAT_FULL;
                            state_next      = toeq_pkg::ST_FIN_RD;
                        end else begin
                            cmd.pos_occ = 1'b1;
                            cmd.k_occ   = 1'b1;
                            state_next  = toeq_pkg::ST_SHIFT_UP_CHK;
                        end
                    end
                    toeq_pkg::FUNC_POP: begin
                        if (stat.occ_zero) begin
                            cmd.status_load = 1'b1;
                            cmd.status_val  = toeq_pkg::STAT_EMPTY;
                            state_next      = toeq_pkg::ST_FIN_RD;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = toeq_pkg::RD_ZERO;
                            state_next = toeq_pkg::ST_POP_CAP;
                        end
                    end
                    default: begin
                        state_next = toeq_pkg::ST_FIN_RD;
                    end
                endcase
            end
            toeq_pkg::ST_INS_HEAD: begin
                if (stat.head_ge) begin
                    if (stat.occ_full) begin
                        cmd.status_load = 1'b1;
                        cmd.status_val  = toeq_pkg::STAT_FULL;
                        state_next      = toeq_pkg::ST_FIN_RD;
                    end else begin
                        cmd.pos_zero = 1'b1;
                        cmd.k_occ    = 1'b1;
                        state_next   = toeq_pkg::ST_SHIFT_UP_CHK;
                    end
                end else begin
                    cmd.prev_load = 1'b1;
                    cmd.pos_one   = 1'b1;
                    state_next    = toeq_pkg::ST_SCAN_RD;
                end
            end
            toeq_pkg::ST_SCAN_RD: begin
                if (stat.pos_lt_occ) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = toeq_pkg::RD_POS;
                    state_next = toeq_pkg::ST_SCAN_CHK;
                end else begin
                    state_next = toeq_pkg::ST_INS_DECIDE;
                end
            end
            toeq_pkg::ST_SCAN_CHK: begin
                if (stat.rd_le) begin
                    cmd.prev_load = 1'b1;
                    cmd.pos_inc   = 1'b1;
                    state_next    = toeq_pkg::ST_SCAN_RD;
                end else begin
                    state_next = toeq_pkg::ST_INS_DECIDE;
                end
            end
            toeq_pkg::ST_INS_DECIDE: begin
                if (stat.dup) begin
                    cmd.status_load = 1'b1;
                    cmd.status_val  = toeq_pkg::STAT_DUP;
                    state_next      = toeq_pkg::ST_FIN_RD;
                end else if (stat.occ_full) begin
                    cmd.status_load = 1'b1;
                    cmd.status_val  = toeq_pkg::STAT_FULL;
                    state_next      = toeq_pkg::ST_FIN_RD;
                end else begin
                    cmd.k_occ  = 1'b1;
                    state_next = toeq_pkg::ST_SHIFT_UP_CHK;
                end
            end
            toeq_pkg::ST_SHIFT_UP_CHK: begin
                if (stat.k_gt_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = toeq_pkg::RD_KM1;
                    state_next = toeq_pkg::ST_SHIFT_UP_WR;
                end else begin
                    state_next = toeq_pkg::ST_PUT;
                end
            end
            toeq_pkg::ST_SHIFT_UP_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = toeq_pkg::WR_K;
                cmd.k_dec  = 1'b1;
                state_next = toeq_pkg::ST_SHIFT_UP_CHK;
            end
            toeq_pkg::ST_PUT: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = toeq_pkg::WR_POS;
                cmd.wr_new  = 1'b1;
                cmd.occ_inc = 1'b1;
                state_next  = toeq_pkg::ST_FIN_RD;
            end
            toeq_pkg::ST_POP_CAP: begin
                cmd.pop_cap = 1'b1;
                cmd.k_one   = 1'b1;
                state_next  = toeq_pkg::ST_SHIFT_DN_CHK;
            end
            toeq_pkg::ST_SHIFT_DN_CHK: begin
                if (stat.k_lt_occ) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = toeq_pkg::RD_K;
                    state_next = toeq_pkg::ST_SHIFT_DN_WR;
                end else begin
                    cmd.occ_dec = 1'b1;
                    state_next  = toeq_pkg::ST_FIN_RD;
                end
            end
            toeq_pkg::ST_SHIFT_DN_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = toeq_pkg::WR_KM1;
                cmd.k_inc  = 1'b1;
                state_next = toeq_pkg::ST_SHIFT_DN_CHK;
            end
            toeq_pkg::ST_FIN_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = toeq_pkg::RD_ZERO;
                state_next = toeq_pkg::ST_FIN_CAP;
            end
            toeq_pkg::ST_FIN_CAP: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = toeq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = toeq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/toeq_dpath.sv]
// ----------------------------------------------------------------------------
// toeq_dpath
// entry memory, occupancy and scan/shift counters, request and result registers
// ----------------------------------------------------------------------------
module toeq_dpath #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TIME_BITS   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [toeq_pkg::S_DATA_BITS-1:0]    s_tdata,
    input  logic [toeq_pkg::FUNC_BITS-1:0]      s_tuser,
    input  toeq_pkg::toeq_cmd_t                 cmd,
    output toeq_pkg::toeq_stat_t                stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [toeq_pkg::M_DATA_BITS-1:0]    m_tdata,
    output logic [toeq_pkg::STAT_BITS-1:0]      m_tuser
);

    localparam int unsigned ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned ID_W    = toeq_pkg::ID_BITS;
    localparam int unsigned ENTRY_W = TIME_BITS + ID_W;
    localparam int unsigned PT_W    = toeq_pkg::PORT_TIME_BITS;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

    toeq_pkg::func_t    func_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [ID_W-1:0]    id_reg;
    logic [CNT_W-1:0]   occ_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [ID_W-1:0]    prev_id_reg;
    toeq_pkg::status_t  status_reg;
    logic [TIME_BITS-1:0] pop_time_reg;
    logic [ID_W-1:0]    pop_id_reg;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               m_tvalid_reg;
    logic [toeq_pkg::M_DATA_BITS-1:0] m_tdata_reg;
    logic [toeq_pkg::STAT_BITS-1:0]   m_tuser_reg;

    logic [CNT_W-1:0]     k_m1;
    logic [CNT_W-1:0]     raddr_full;
    logic [CNT_W-1:0]     waddr_full;
    logic [ENTRY_W-1:0]   wdata;
    logic [TIME_BITS-1:0] rd_time;
    logic [ID_W-1:0]      rd_id;
    logic                 head_valid;
    logic [PT_W-1:0]      head_time;
    logic [ID_W-1:0]      head_id;

    assign k_m1    = k_reg - 1'b1;
    assign rd_time = rdata_reg[TIME_BITS-1:0];
    assign rd_id   = rdata_reg[ENTRY_W-1:TIME_BITS];
    assign wdata   = cmd.wr_new ? {id_reg, time_reg} : rdata_reg;

    always_comb begin
        case (cmd.rd_sel)
            toeq_pkg::RD_ZERO: raddr_full = '0;
            toeq_pkg::RD_POS:  raddr_full = pos_reg;
            toeq_pkg::RD_K:    raddr_full = k_reg;
            toeq_pkg::RD_KM1:  raddr_full = k_m1;
            default:           raddr_full = '0;
        endcase
    end

    always_comb begin
        case (cmd.wr_sel)
            toeq_pkg::WR_POS: waddr_full = pos_reg;
            toeq_pkg::WR_K:   waddr_full = k_reg;
            toeq_pkg::WR_KM1: waddr_full = k_m1;
            default:          waddr_full = pos_reg;
        endcase
    end

    // entry store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[waddr_full[ADDR_W-1:0]] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[raddr_full[ADDR_W-1:0]];
        end
    end

    // request registers, scan and shift counters
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg     <= toeq_pkg::func_t'(s_tuser);
            time_reg     <= TIME_BITS'(s_tdata[PT_W-1:0]);
            id_reg       <= s_tdata[PT_W+ID_W-1:PT_W];
            status_reg   <= toeq_pkg::STAT_OK;
            pop_time_reg <= '0;
            pop_id_reg   <= '0;
        end else if (cmd.status_load) begin
            status_reg <= cmd.status_val;
        end
        if (cmd.pop_cap) begin
            pop_time_reg <= rd_time;
            pop_id_reg   <= rd_id;
        end
        if (cmd.prev_load) begin
            prev_id_reg <= rd_id;
        end
        if (cmd.pos_zero) begin
            pos_reg <= '0;
        end else if (cmd.pos_one) begin
            pos_reg <= CNT_W'(1);
        end else if (cmd.pos_occ) begin
            pos_reg <= occ_reg;
        end else if (cmd.pos_inc) begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.k_occ) begin
            k_reg <= occ_reg;
        end else if (cmd.k_one) begin
            k_reg <= CNT_W'(1);
        end else if (cmd.k_dec) begin
            k_reg <= k_m1;
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.occ_inc) begin
            occ_reg <= occ_reg + 1'b1;
        end else if (cmd.occ_dec) begin
            occ_reg <= occ_reg - 1'b1;
        end
    end

    assign head_valid = (occ_reg != '0);
    assign head_time  = head_valid ? PT_W'(rd_time) : '0;
    assign head_id    = head_valid ? rd_id : '0;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {2'b00, toeq_pkg::COUNT_BITS'(occ_reg), head_id, head_time,
                            head_valid, pop_id_reg, PT_W'(pop_time_reg)};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign stat.func       = func_reg;
    assign stat.occ_zero   = (occ_reg == '0);
    assign stat.occ_full   = (occ_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.head_ge    = (rd_time >= time_reg);
    assign stat.rd_le      = (rd_time <= time_reg);
    assign stat.pos_lt_occ = (pos_reg < occ_reg);
    assign stat.dup        = (prev_id_reg == id_reg);
    assign stat.k_gt_pos   = (k_reg > pos_reg);
    assign stat.k_lt_occ   = (k_reg < occ_reg);
    assign stat.out_busy   = m_tvalid_reg && !m_tready;

endmodule

[rtl/core/time_ordered_event_queue_core.sv]
// ----------------------------------------------------------------------------
// time_ordered_event_queue_core
// bounded event queue held in ascending time order
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser carries the operation (ordered
// insert, append at tail, pop head), s_tdata the event time and id. Each
// request gives exactly one result on the m_ channel: m_tuser carries the
// status, m_tdata the popped event, the head after the operation and the
// entry count.
// One request is worked at a time by a sequencer over the entry memory. An
// ordered insert reads the head, then scans forward with a read and a check
// per entry passed and moves each displaced entry up with a read and a write;
// a pop moves each remaining entry down with a read and a write.
// The result sits in an output register, so a stalled receiver holds only the
// final hand-off; the next request is taken as soon as the sequencer is back
// in idle. Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "time_ordered_event_queue_core_defines.svh"

module time_ordered_event_queue_core #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TIME_BITS   = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // event_time [31:0], event_id [47:32]
    input  logic [toeq_pkg::S_DATA_BITS-1:0] s_tdata,
    // func [1:0]
    input  logic [toeq_pkg::FUNC_BITS-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // popped_time [31:0], popped_id [47:32], head_valid [48],
    // head_time [80:49], head_id [96:81], entry_count [101:97]
    output logic [toeq_pkg::M_DATA_BITS-1:0] m_tdata,
    // status [1:0]
    output logic [toeq_pkg::STAT_BITS-1:0]   m_tuser
);

    toeq_pkg::toeq_cmd_t  cmd;
    toeq_pkg::toeq_stat_t stat;

    toeq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    toeq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // checks
    `TOEQ_ASSERT(a_full_count, aclk, aresetn, (m_tvalid && m_tuser == toeq_pkg::STAT_FULL) |-> (m_tdata[101:97] == toeq_pkg::COUNT_BITS'(QUEUE_DEPTH)), "full status with a count other than the depth")
    `TOEQ_ASSERT(a_empty_head, aclk, aresetn, (m_tvalid && m_tuser == toeq_pkg::STAT_EMPTY) |-> (!m_tdata[48] && m_tdata[101:97] == '0), "empty status with a head or a count")
    `TOEQ_ASSERT(a_pop_fields, aclk, aresetn, (m_tvalid && m_tuser != toeq_pkg::STAT_OK) |-> (m_tdata[47:0] == '0), "popped fields set on a failed request")
    `TOEQ_ASSERT(a_no_accept_busy, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "request taken while the previous one is in flight")

endmodule
